[hw/rtl/sha512_pkg.sv]
// Shared types, constants and round functions of the SHA-512 hash engine.
// Used by the interfaces, the schedule, the round core and the top level.
package sha512_pkg;

   localparam int WORD_W      = 64;
   localparam int BLOCK_WORDS = 16;
   localparam int HASH_WORDS  = 8;
   localparam int ROUNDS      = 80;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [6:0]        round_type;

   typedef struct packed {
      logic push;
      logic start;
      logic step;
      logic add;
      logic shift;
      logic reinit;
   } ctl_type;

   localparam round_type LAST_ROUND = round_type'(ROUNDS - 1);
   localparam logic [3:0] FULL_BYTES = 4'd8;
   localparam logic [3:0] LAST_SLOT  = 4'(BLOCK_WORDS - 1);
   localparam logic [3:0] LEN_SLOT   = 4'(BLOCK_WORDS - 2);
   localparam word_type   MARK_WORD  = 64'h8000_0000_0000_0000;

   function automatic word_type rotr(word_type x, int n);
      return (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic word_type big_sigma0(word_type x);
      return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic word_type big_sigma1(word_type x);
      return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

   function automatic word_type small_sigma0(word_type x);
      return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic word_type small_sigma1(word_type x);
      return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

   function automatic word_type choose(word_type e, word_type f, word_type g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic word_type majority(word_type a, word_type b, word_type c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

   // keep the top bytes in use, then place the pad byte right after them
   function automatic word_type pad_word(word_type data, logic [2:0] nbytes);
      word_type keep;
      keep = ~({WORD_W{1'b1}} >> {nbytes, 3'b000});
      return (data & keep) | (MARK_WORD >> {nbytes, 3'b000});
   endfunction

   function automatic word_type init_hash(logic [2:0] idx);
      word_type v;
      unique case (idx)
         3'd0: v = 64'h6a09e667f3bcc908;
         3'd1: v = 64'hbb67ae8584caa73b;
         3'd2: v = 64'h3c6ef372fe94f82b;
         3'd3: v = 64'ha54ff53a5f1d36f1;
         3'd4: v = 64'h510e527fade682d1;
         3'd5: v = 64'h9b05688c2b3e6c1f;
         3'd6: v = 64'h1f83d9abfb41bd6b;
         default: v = 64'h5be0cd19137e2179;
      endcase
      return v;
   endfunction

   function automatic word_type round_const(round_type idx);
      word_type v;
      unique case (idx)
         7'd0:  v = 64'h428a2f98d728ae22;  7'd1:  v = 64'h7137449123ef65cd;
         7'd2:  v = 64'hb5c0fbcfec4d3b2f;  7'd3:  v = 64'he9b5dba58189dbbc;
         7'd4:  v = 64'h3956c25bf348b538;  7'd5:  v = 64'h59f111f1b605d019;
         7'd6:  v = 64'h923f82a4af194f9b;  7'd7:  v = 64'hab1c5ed5da6d8118;
         7'd8:  v = 64'hd807aa98a3030242;  7'd9:  v = 64'h12835b0145706fbe;
         7'd10: v = 64'h243185be4ee4b28c;  7'd11: v = 64'h550c7dc3d5ffb4e2;
         7'd12: v = 64'h72be5d74f27b896f;  7'd13: v = 64'h80deb1fe3b1696b1;
         7'd14: v = 64'h9bdc06a725c71235;  7'd15: v = 64'hc19bf174cf692694;
         7'd16: v = 64'he49b69c19ef14ad2;  7'd17: v = 64'hefbe4786384f25e3;
         7'd18: v = 64'h0fc19dc68b8cd5b5;  7'd19: v = 64'h240ca1cc77ac9c65;
         7'd20: v = 64'h2de92c6f592b0275;  7'd21: v = 64'h4a7484aa6ea6e483;
         7'd22: v = 64'h5cb0a9dcbd41fbd4;  7'd23: v = 64'h76f988da831153b5;
         7'd24: v = 64'h983e5152ee66dfab;  7'd25: v = 64'ha831c66d2db43210;
         7'd26: v = 64'hb00327c898fb213f;  7'd27: v = 64'hbf597fc7beef0ee4;
         7'd28: v = 64'hc6e00bf33da88fc2;  7'd29: v = 64'hd5a79147930aa725;
         7'd30: v = 64'h06ca6351e003826f;  7'd31: v = 64'h142929670a0e6e70;
         7'd32: v = 64'h27b70a8546d22ffc;  7'd33: v = 64'h2e1b21385c26c926;
         7'd34: v = 64'h4d2c6dfc5ac42aed;  7'd35: v = 64'h53380d139d95b3df;
         7'd36: v = 64'h650a73548baf63de;  7'd37: v = 64'h766a0abb3c77b2a8;
         7'd38: v = 64'h81c2c92e47edaee6;  7'd39: v = 64'h92722c851482353b;
         7'd40: v = 64'ha2bfe8a14cf10364;  7'd41: v = 64'ha81a664bbc423001;
         7'd42: v = 64'hc24b8b70d0f89791;  7'd43: v = 64'hc76c51a30654be30;
         7'd44: v = 64'hd192e819d6ef5218;  7'd45: v = 64'hd69906245565a910;
         7'd46: v = 64'hf40e35855771202a;  7'd47: v = 64'h106aa07032bbd1b8;
         7'd48: v = 64'h19a4c116b8d2d0c8;  7'd49: v = 64'h1e376c085141ab53;
         7'd50: v = 64'h2748774cdf8eeb99;  7'd51: v = 64'h34b0bcb5e19b48a8;
         7'd52: v = 64'h391c0cb3c5c95a63;  7'd53: v = 64'h4ed8aa4ae3418acb;
         7'd54: v = 64'h5b9cca4f7763e373;  7'd55: v = 64'h682e6ff3d6b2b8a3;
         7'd56: v = 64'h748f82ee5defb2fc;  7'd57: v = 64'h78a5636f43172f60;
         7'd58: v = 64'h84c87814a1f0ab72;  7'd59: v = 64'h8cc702081a6439ec;
         7'd60: v = 64'h90befffa23631e28;  7'd61: v = 64'ha4506cebde82bde9;
         7'd62: v = 64'hbef9a3f7b2c67915;  7'd63: v = 64'hc67178f2e372532b;
         7'd64: v = 64'hca273eceea26619c;  7'd65: v = 64'hd186b8c721c0c207;
         7'd66: v = 64'heada7dd6cde0eb1e;  7'd67: v = 64'hf57d4f7fee6ed178;
         7'd68: v = 64'h06f067aa72176fba;  7'd69: v = 64'h0a637dc5a2c898a6;
         7'd70: v = 64'h113f9804bef90dae;  7'd71: v = 64'h1b710b35131c471b;
         7'd72: v = 64'h28db77f523047d84;  7'd73: v = 64'h32caab7b40c72493;
         7'd74: v = 64'h3c9ebe0a15c9bebc;  7'd75: v = 64'h431d67c49c100d4c;
         7'd76: v = 64'h4cc5d4becb3e42b6;  7'd77: v = 64'h597f299cfc657e2a;
         7'd78: v = 64'h5fcb6fab3ad6faec;  7'd79: v = 64'h6c44198c4a475817;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/sha512_if.sv]
// Valid/ready channel interfaces for message words in and digest words out.
// Depends on sha512_pkg for the word type.
interface sha512_req_if import sha512_pkg::*;;
   logic       valid;
   logic       ready;
   word_type   data_word;
   logic [3:0] valid_bytes;
   logic       last_of_message;

   modport source(output valid, data_word, valid_bytes, last_of_message, input ready);
   modport sink(input valid, data_word, valid_bytes, last_of_message, output ready);
endinterface

interface sha512_rsp_if import sha512_pkg::*;;
   logic     valid;
   logic     ready;
   word_type digest_word;
   logic     digest_last;

   modport source(output valid, digest_word, digest_last, input ready);
   modport sink(input valid, digest_word, digest_last, output ready);
endinterface

[hw/rtl/sha512_hash_engine.sv]
// SHA-512 engine. Message words are taken in idle; every 16th word starts
// 80 rounds of the shared round core plus one hash add before the next is taken.
// The final word adds up to 16 pad/length pushes per padded block and one or two
// compressions, then 8 digest beats, one per cycle while the sink is ready.
// Synchronous active-high reset loads the initial hash and clears counts.
module sha512_hash_engine import sha512_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   sha512_req_if.sink         req_chan,
   sha512_rsp_if.source       rsp_chan
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_COMP = 3'd2;
   localparam logic [2:0] ST_ADD  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   localparam logic [1:0] PH_MARK = 2'd0;
   localparam logic [1:0] PH_ZERO = 2'd1;
   localparam logic [1:0] PH_LO   = 2'd2;

   logic [2:0]   state_ff, state_in;
   round_type    round_ff, round_in;
   logic [3:0]   wib_ff, wib_in;
   logic [127:0] count_ff, count_in;
   logic         pad_ff, pad_in;
   logic [1:0]   phase_ff, phase_in;
   logic         done_ff, done_in;
   logic [2:0]   beat_ff, beat_in;

   ctl_type      ctl;
   word_type     push_word;
   round_type    k_index;
   word_type     kw;
   word_type     digest_word;
   logic         req_beat;
   logic         rsp_beat;
   logic         last;
   logic [3:0]   nbytes;
   word_type     len_hi;
   word_type     len_lo;

   assign req_beat = req_chan.valid && req_chan.ready;
   assign rsp_beat = rsp_chan.valid && rsp_chan.ready;
   assign last     = req_chan.last_of_message;
   assign nbytes   = (!last || req_chan.valid_bytes > FULL_BYTES) ? FULL_BYTES
                                                                  : req_chan.valid_bytes;
   assign len_hi   = count_ff[124:61];
   assign len_lo   = {count_ff[60:0], 3'b000};

   always_comb begin
      state_in  = state_ff;
      round_in  = round_ff;
      wib_in    = wib_ff;
      count_in  = count_ff;
      pad_in    = pad_ff;
      phase_in  = phase_ff;
      done_in   = done_ff;
      beat_in   = beat_ff;
      ctl       = '0;
      push_word = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               ctl.push = 1'b1;
               count_in = count_ff + 128'(nbytes);
               pad_in   = last;
               if (nbytes == FULL_BYTES) begin
                  push_word = req_chan.data_word;
                  phase_in  = PH_MARK;
               end else begin
                  push_word = pad_word(req_chan.data_word, nbytes[2:0]);
                  phase_in  = PH_ZERO;
               end
               if (last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            ctl.push = 1'b1;
            case (phase_ff)
               PH_MARK: begin
                  push_word = MARK_WORD;
                  phase_in  = PH_ZERO;
               end
               PH_ZERO: begin
                  if (wib_ff == LEN_SLOT) begin
                     push_word = len_hi;
                     phase_in  = PH_LO;
                  end
               end
               PH_LO: begin
                  push_word = len_lo;
                  done_in   = 1'b1;
               end
               default: push_word = '0;
            endcase
         end
         ST_COMP: begin
            ctl.step = 1'b1;
            round_in = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            ctl.add = 1'b1;
            if (done_ff) begin
               state_in = ST_OUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_beat) begin
               ctl.shift = 1'b1;
               beat_in   = beat_ff + 3'd1;
               if (beat_ff == 3'(HASH_WORDS - 1)) begin
                  ctl.reinit = 1'b1;
                  count_in   = '0;
                  pad_in     = 1'b0;
                  done_in    = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (ctl.push) begin
         if (wib_ff == LAST_SLOT) begin
            wib_in    = '0;
            ctl.start = 1'b1;
            round_in  = '0;
            state_in  = ST_COMP;
         end else begin
            wib_in = wib_ff + 4'd1;
         end
      end

      k_index = ctl.start ? round_type'(0) : round_ff + 7'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         wib_ff   <= '0;
         count_ff <= '0;
         pad_ff   <= 1'b0;
         phase_ff <= PH_MARK;
         done_ff  <= 1'b0;
         beat_ff  <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         wib_ff   <= wib_in;
         count_ff <= count_in;
         pad_ff   <= pad_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
         beat_ff  <= beat_in;
      end
   end

   sha512_sched u_sched (
      .clock     (clock),
      .ctl       (ctl),
      .push_word (push_word),
      .k_index   (k_index),
      .kw        (kw)
   );

   sha512_core u_core (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .kw          (kw),
      .digest_word (digest_word)
   );

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = (state_ff == ST_OUT);
   assign rsp_chan.digest_word = digest_word;
   assign rsp_chan.digest_last = (beat_ff == 3'(HASH_WORDS - 1));

endmodule

[hw/rtl/sha512_sched.sv]
// Message schedule: 16-word sliding window loaded one word per push, then
// expanded one word per round; also registers K[t] + W[t] for the round core.
module sha512_sched import sha512_pkg::*; (
   input  logic      clock,
   input  ctl_type   ctl,
   input  word_type  push_word,
   input  round_type k_index,
   output word_type  kw
);

   word_type win_ff [BLOCK_WORDS];
   word_type win_in [BLOCK_WORDS];
   word_type next_w;
   word_type kw_ff;
   word_type kw_in;

   always_comb begin
      next_w = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
         win_in[i] = win_ff[i + 1];
      end
      win_in[BLOCK_WORDS - 1] = ctl.step ? next_w : push_word;
      kw_in = round_const(k_index) + win_ff[1];
   end

   always_ff @(posedge clock) begin
      if (ctl.push || ctl.step) begin
         win_ff <= win_in;
         kw_ff  <= kw_in;
      end
   end

   assign kw = kw_ff;

endmodule

[hw/rtl/sha512_core.sv]
// Round core: working variables a..h, one compression round per cycle, and the
// eight-word hash state that accumulates and shifts out the digest.
module sha512_core import sha512_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  ctl_type  ctl,
   input  word_type kw,
   output word_type digest_word
);

   word_type work_ff [HASH_WORDS];
   word_type work_in [HASH_WORDS];
   word_type hash_ff [HASH_WORDS];
   word_type t1;
   word_type t2;

   always_comb begin
      t1 = work_ff[7] + big_sigma1(work_ff[4]) + choose(work_ff[4], work_ff[5], work_ff[6]) + kw;
      t2 = big_sigma0(work_ff[0]) + majority(work_ff[0], work_ff[1], work_ff[2]);
      for (int i = 1; i < HASH_WORDS; i++) begin
         work_in[i] = work_ff[i - 1];
      end
      work_in[0] = t1 + t2;
      work_in[4] = work_ff[3] + t1;
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         work_ff <= hash_ff;
      end else if (ctl.step) begin
         work_ff <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.reinit) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            hash_ff[i] <= init_hash(3'(i));
         end
      end else if (ctl.add) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            hash_ff[i] <= hash_ff[i] + work_ff[i];
         end
      end else if (ctl.shift) begin
         for (int i = 0; i < HASH_WORDS - 1; i++) begin
            hash_ff[i] <= hash_ff[i + 1];
         end
         hash_ff[HASH_WORDS - 1] <= hash_ff[0];
      end
   end

   assign digest_word = hash_ff[0];

endmodule

[hw/rtl/sha512_chk.sv]
// Port-level checker for the SHA-512 engine, bound to the top level.
// Sees only the channel handshakes and the last_of_message and digest_last flags.
module sha512_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("engine not idle after reset");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while digest pending");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> !req_ready)
      else $error("ready right after final word");

   a_digest_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("digest beats interrupted");

   a_digest_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> (!rsp_valid && req_ready))
      else $error("digest continues past last beat");

endmodule

bind sha512_hash_engine sha512_chk u_sha512_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.last_of_message),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_last  (rsp_chan.digest_last)
);

[dv/sha512_hash_engine_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for sha512_hash_engine: random and directed messages are hashed by
// a local SHA-512 predictor, and every digest beat is checked in order.
// Depends on sha512_pkg and the sha512_req_if / sha512_rsp_if channel interfaces.
module sha512_hash_engine_test;
   import sha512_pkg::*;

   typedef struct packed {
      word_type   data_word;
      logic [3:0] valid_bytes;
      logic       last_of_message;
   } msg_beat_type;

   typedef struct packed {
      word_type digest_word;
      logic     digest_last;
   } digest_beat_type;

   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_SEND_GAPS,
      FLOW_RECV_STALLS,
      FLOW_BOTH
   } flow_mode_type;

   localparam int       MAX_SHOWN   = 10;
   localparam int       LONG_HOLD   = 800;
   localparam int       TAIL_CYCLES = 300;
   localparam int       PHASE_WORDS = 100;
   localparam word_type PAD_TOP     = 64'h8000_0000_0000_0000;

   word_type chain_iv [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   word_type round_k [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha512_req_if req_if ();
   sha512_rsp_if rsp_if ();

   sha512_hash_engine uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #2 clock = ~clock;

   msg_beat_type    msg_word_q [$];
   digest_beat_type digest_due_q [$];
   flow_mode_type   flow = FLOW_FREE;
   logic            req_fire = 1'b0;
   logic            rsp_hold = 1'b0;
   logic            squeeze_go = 1'b0;
   int              failures = 0;
   int              msgs_queued = 0;
   int              words_taken = 0;
   int              digests_seen = 0;

   word_type     chain_h [8];
   word_type     blk_w [16];
   logic [127:0] msg_bytes;
   int           blk_fill;

   function automatic word_type ror(word_type x, int n);
      return word_type'({x, x} >> n);
   endfunction

   function automatic void reset_chain();
      for (int k = 0; k < 8; k++) chain_h[k] = chain_iv[k];
      msg_bytes = '0;
      blk_fill  = 0;
   endfunction

   function automatic void compress_blk();
      word_type sched [80];
      word_type a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 16; t++) sched[t] = blk_w[t];
      for (int t = 16; t < 80; t++) begin
         s0 = ror(sched[t-15], 1) ^ ror(sched[t-15], 8) ^ (sched[t-15] >> 7);
         s1 = ror(sched[t-2], 19) ^ ror(sched[t-2], 61) ^ (sched[t-2] >> 6);
         sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
      end
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (int t = 0; t < 80; t++) begin
         t1 = h + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41)) + ((e & f) ^ (~e & g))
            + round_k[t] + sched[t];
         t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endfunction

   function automatic void absorb_word(word_type w);
      blk_w[blk_fill] = w;
      blk_fill++;
      if (blk_fill == 16) begin
         compress_blk();
         blk_fill = 0;
      end
   endfunction

   function automatic void hash_beat(word_type data, logic [3:0] vb, logic fin);
      int              nb;
      word_type        tail;
      digest_beat_type due;
      nb = (!fin || vb > 4'd8) ? 8 : int'(vb);
      msg_bytes += 128'(nb);
      if (!fin) begin
         absorb_word(data);
         return;
      end
      if (nb == 8) begin
         absorb_word(data);
         tail = PAD_TOP;
      end else begin
         tail = (data & ~({64{1'b1}} >> (8 * nb))) | (PAD_TOP >> (8 * nb));
      end
      absorb_word(tail);
      if (blk_fill > 14) while (blk_fill != 0) absorb_word('0);
      while (blk_fill < 14) absorb_word('0);
      absorb_word(msg_bytes[124:61]);
      absorb_word({msg_bytes[60:0], 3'b000});
      for (int k = 0; k < 8; k++) begin
         due.digest_word = chain_h[k];
         due.digest_last = (k == 7);
         digest_due_q.push_back(due);
      end
      reset_chain();
   endfunction

   function automatic void note_failure(string msg);
      failures++;
      if (failures <= MAX_SHOWN) $display("MISMATCH @%0t: %s", $time, msg);
   endfunction

   function automatic void queue_word(word_type data, logic [3:0] vb, logic fin);
      msg_beat_type beat;
      beat.data_word       = data;
      beat.valid_bytes     = vb;
      beat.last_of_message = fin;
      msg_word_q.push_back(beat);
      if (fin) msgs_queued++;
   endfunction

   function automatic word_type rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic int queue_message();
      int          len;
      int unsigned pick;
      logic [3:0]  vb;
      pick = $urandom_range(99);
      if (pick < 55)      len = $urandom_range(16, 1);
      else if (pick < 85) len = $urandom_range(18, 12);
      else if (pick < 97) len = $urandom_range(40, 17);
      else                len = $urandom_range(80, 41);
      for (int i = 0; i < len - 1; i++) begin
         vb = ($urandom_range(99) < 85) ? 4'd8 : 4'($urandom_range(15));
         queue_word(rand_word(), vb, 1'b0);
      end
      vb = ($urandom_range(99) < 80) ? 4'($urandom_range(8)) : 4'($urandom_range(15));
      queue_word(rand_word(), vb, 1'b1);
      return len;
   endfunction

   task automatic wait_idle();
      while (msg_word_q.size() != 0 || req_if.valid || digest_due_q.size() != 0)
         @(posedge clock);
   endtask

   // sender: advance only after the current beat was taken
   always @(negedge clock) begin
      msg_beat_type beat;
      logic         offer;
      if (!req_if.valid || req_fire) begin
         offer = msg_word_q.size() != 0
               && !(flow == FLOW_SEND_GAPS && $urandom_range(99) < 75)
               && !(flow == FLOW_BOTH && $urandom_range(99) < 9);
         if (offer) begin
            beat = msg_word_q.pop_front();
            req_if.data_word       <= beat.data_word;
            req_if.valid_bytes     <= beat.valid_bytes;
            req_if.last_of_message <= beat.last_of_message;
         end
         req_if.valid <= offer;
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= !rsp_hold
                    && !(flow == FLOW_RECV_STALLS && $urandom_range(99) < 75)
                    && !(flow == FLOW_BOTH && $urandom_range(99) < 9);
   end

   always @(posedge clock) begin
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         words_taken++;
         hash_beat(req_if.data_word, req_if.valid_bytes, req_if.last_of_message);
      end
   end

   always @(posedge clock) begin
      digest_beat_type due;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         digests_seen++;
         if (digest_due_q.size() == 0) begin
            note_failure($sformatf("unexpected digest beat %h last=%b",
                                   rsp_if.digest_word, rsp_if.digest_last));
         end else begin
            due = digest_due_q.pop_front();
            if (rsp_if.digest_word !== due.digest_word)
               note_failure($sformatf("digest word: expected %h, got %h",
                                      due.digest_word, rsp_if.digest_word));
            if (rsp_if.digest_last !== due.digest_last)
               note_failure($sformatf("digest last: expected %b, got %b",
                                      due.digest_last, rsp_if.digest_last));
         end
      end
   end

   // hold the receiver off while the sender keeps pushing
   initial begin
      wait (squeeze_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #(2_000_000);
      $display("TIMEOUT: %0d digest beats still due", digest_due_q.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int phase_words;
      req_if.valid           = 1'b0;
      req_if.data_word       = '0;
      req_if.valid_bytes     = '0;
      req_if.last_of_message = 1'b0;
      rsp_if.ready           = 1'b0;
      reset_chain();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      queue_word({64{1'b1}}, 4'd0, 1'b1);
      queue_word(64'h6162_63ff_ffff_ffff, 4'd3, 1'b1);
      queue_word({64{1'b1}}, 4'd8, 1'b1);
      queue_word('0, 4'd15, 1'b1);
      queue_word({64{1'b1}}, 4'd0, 1'b0);
      queue_word(rand_word(), 4'd3, 1'b0);
      queue_word(rand_word(), 4'd9, 1'b0);
      for (int i = 0; i < 11; i++) queue_word(rand_word(), 4'd8, 1'b0);
      queue_word({64{1'b1}}, 4'd0, 1'b1);
      queue_word('0, 4'd15, 1'b0);
      queue_word({64{1'b1}}, 4'd7, 1'b1);
      wait_idle();

      for (int p = 0; p < 4; p++) begin
         flow = flow_mode_type'(p);
         phase_words = 0;
         while (phase_words < PHASE_WORDS) phase_words += queue_message();
         if (flow == FLOW_FREE) squeeze_go = 1'b1;
         wait_idle();
      end

      flow = FLOW_FREE;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (digest_due_q.size() != 0)
         note_failure($sformatf("%0d digest beats never arrived", digest_due_q.size()));
      $display("Hashed %0d messages from %0d accepted words; %0d digest beats checked.",
               msgs_queued, words_taken, digests_seen);
      $display("Covered free flow, sender gaps, receiver stalls, mixed idling and a long hold.");
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
